FILE: design/pcpt_pkg.sv
// ----------------------------------------------------------------------------
// pcpt_pkg: shared types and constants of the curve point and tangent block
// Fixed-point constants, CORDIC arctangent steps, pipeline word types and
// small arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcpt_pkg;

    localparam int unsigned RED_STEPS = 6;

    localparam logic [26:0] TWO_PI_Q24  = 27'd105414357;
    localparam logic [26:0] PI_Q24      = 27'd52707179;
    localparam logic [26:0] HALF_PI_Q24 = 27'd26353589;
    // 21 full turns, lifts any angle to a non-negative value
    localparam logic [32:0] TURN_OFFSET = 33'd2213701497;

    localparam logic signed [31:0] GAIN_Q30       = 32'sd652032874;
    localparam logic [29:0]        INV_TWO_PI_Q32 = 30'd683565276;

    localparam logic signed [63:0] MAX48_64 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] MIN48_64 = 64'shFFFF_8000_0000_0000;

    localparam logic signed [31:0] ATAN_TABLE [10] = '{
        32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158,
        32'sd67021686,  32'sd33543515,  32'sd16775850,  32'sd8388437,
        32'sd4194282,   32'sd2097149
    };

    typedef enum logic [1:0] {
        CURVE_CIRCLE  = 2'd0,
        CURVE_ELLIPSE = 2'd1,
        CURVE_HELIX   = 2'd2
    } t_curve;

    typedef enum logic [1:0] {
        CFG_CURVE_KIND = 2'd0,
        CFG_RADIUS_X   = 2'd1,
        CFG_RADIUS_Y   = 2'd2,
        CFG_PITCH      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        radius_x;
        logic [31:0]        radius_y;
        logic signed [31:0] pitch;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic               neg;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [47:0] pz;
    } t_cordic_word;

    typedef struct packed {
        logic signed [47:0] point_x;
        logic signed [47:0] point_y;
        logic signed [47:0] point_z;
        logic signed [47:0] tangent_x;
        logic signed [47:0] tangent_y;
        logic signed [47:0] tangent_z;
        logic [1:0]         kind;
    } t_result;

    function automatic logic signed [31:0] atan_entry(input int unsigned idx);
        logic [31:0] pow;
        logic signed [31:0] val;
        pow = 32'd0;
        if (idx < 10) begin
            val = ATAN_TABLE[idx[3:0]];
        end else if (idx < 30) begin
            pow = 32'd1 << (30 - idx);
            val = $signed(pow - 32'd1);
        end else begin
            val = '0;
        end
        return val;
    endfunction

    // divide by 2^30, round half away from zero
    function automatic logic signed [33:0] round30(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd536870912 - {63'd0, v[63]};
        return t[63:30];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] res;
        if (v > MAX48_64) begin
            res = MAX48_64[47:0];
        end else if (v < MIN48_64) begin
            res = MIN48_64[47:0];
        end else begin
            res = v[47:0];
        end
        return res;
    endfunction

endpackage

FILE: design/pcpt_reduce.sv
// ----------------------------------------------------------------------------
// pcpt_reduce: angle reduction and helix height
// Reduces the angle modulo two pi over a row of compare-subtract stages,
// folds it into the CORDIC range, and computes pitch*t/(2*pi) alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcpt_reduce (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic signed [31:0]     i_angle,
    input  pcpt_pkg::t_cfg         i_cfg,
    output pcpt_pkg::t_cordic_word o_word
);

    localparam int unsigned STEPS = pcpt_pkg::RED_STEPS;

    logic [STEPS:0]       r_valid;
    logic [32:0]          r_acc [STEPS+1];

    logic signed [63:0]   r_p;
    logic [62:0]          r_m;
    logic                 r_sign1;
    logic [60:0]          r_hi;
    logic [31:0]          r_mlo;
    logic                 r_sign2;
    logic [62:0]          r_lo;
    logic [60:0]          r_hi2;
    logic                 r_sign3;
    logic signed [47:0]   r_pz;
    logic signed [47:0]   r_pz_d1;
    logic signed [47:0]   r_pz_d2;

    pcpt_pkg::t_cordic_word r_word;
    pcpt_pkg::t_cordic_word n_word;

    logic signed [63:0]   n_abs;
    logic [61:0]          n_sum;
    logic signed [38:0]   n_q;
    logic signed [38:0]   n_pz;
    logic [26:0]          n_r;
    logic signed [27:0]   n_w;
    logic signed [27:0]   n_f;
    logic                 n_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0] <= {i_angle[31], i_angle} + pcpt_pkg::TURN_OFFSET;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_sub
        localparam logic [32:0] SUB = {6'd0, pcpt_pkg::TWO_PI_Q24} << (STEPS - 1 - g);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[g+1] <= (r_acc[g] >= SUB) ? r_acc[g] - SUB : r_acc[g];
            end
        end
    end

    always_comb begin
        n_abs = r_p[63] ? -r_p : r_p;
        n_sum = {1'b0, r_hi2} + {31'd0, r_lo[62:32]};
        n_q   = {1'b0, n_sum[61:24]};
        n_pz  = r_sign3 ? -n_q : n_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p     <= i_cfg.pitch * i_angle;
            r_m     <= n_abs[62:0];
            r_sign1 <= r_p[63];
            r_hi    <= {30'd0, r_m[62:32]} * {31'd0, pcpt_pkg::INV_TWO_PI_Q32};
            r_mlo   <= r_m[31:0];
            r_sign2 <= r_sign1;
            r_lo    <= {31'd0, r_mlo} * {33'd0, pcpt_pkg::INV_TWO_PI_Q32}
                       + (63'd1 << 55);
            r_hi2   <= r_hi;
            r_sign3 <= r_sign2;
            r_pz    <= {{9{n_pz[38]}}, n_pz};
            r_pz_d1 <= r_pz;
            r_pz_d2 <= r_pz_d1;
        end
    end

    always_comb begin
        n_r   = r_acc[STEPS][26:0];
        n_neg = 1'b0;
        if (n_r >= pcpt_pkg::PI_Q24) begin
            n_w = $signed({1'b0, n_r}) - $signed({1'b0, pcpt_pkg::TWO_PI_Q24});
        end else begin
            n_w = $signed({1'b0, n_r});
        end
        if (n_w > $signed({1'b0, pcpt_pkg::HALF_PI_Q24})) begin
            n_f   = n_w - $signed({1'b0, pcpt_pkg::PI_Q24});
            n_neg = 1'b1;
        end else if (n_w < -$signed({1'b0, pcpt_pkg::HALF_PI_Q24})) begin
            n_f   = n_w + $signed({1'b0, pcpt_pkg::PI_Q24});
            n_neg = 1'b1;
        end else begin
            n_f = n_w;
        end
        n_word.valid = r_valid[STEPS];
        n_word.neg   = n_neg;
        n_word.x     = pcpt_pkg::GAIN_Q30;
        n_word.y     = '0;
        n_word.z     = $signed({n_f[25:0], 6'b0});
        n_word.pz    = r_pz_d2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

FILE: design/pcpt_cell.sv
// ----------------------------------------------------------------------------
// pcpt_cell: one CORDIC rotation cell
// Rotates the vector by the fixed arctangent of its stage toward zero
// residual angle and hands the word to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcpt_cell #(
    parameter int unsigned STAGE = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  pcpt_pkg::t_cordic_word i_word,
    output pcpt_pkg::t_cordic_word o_word
);

    localparam logic signed [31:0] ANGLE = pcpt_pkg::atan_entry(STAGE);

    pcpt_pkg::t_cordic_word r_word;
    pcpt_pkg::t_cordic_word n_word;
    logic signed [31:0]     n_dx;
    logic signed [31:0]     n_dy;

    always_comb begin
        n_dx   = i_word.y >>> STAGE;
        n_dy   = i_word.x >>> STAGE;
        n_word = i_word;
        if (!i_word.z[31]) begin
            n_word.x = i_word.x - n_dx;
            n_word.y = i_word.y + n_dy;
            n_word.z = i_word.z - ANGLE;
        end else begin
            n_word.x = i_word.x + n_dx;
            n_word.y = i_word.y - n_dy;
            n_word.z = i_word.z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

FILE: design/pcpt_out.sv
// ----------------------------------------------------------------------------
// pcpt_out: radius scaling, rounding and output stage
// Applies the quadrant sign, scales sine and cosine by the radii, rounds,
// saturates and selects by curve kind; an output register and a skid
// register decouple the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcpt_out (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  pcpt_pkg::t_cordic_word i_word,
    input  pcpt_pkg::t_cfg         i_cfg,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic                   o_full,
    output pcpt_pkg::t_result      o_result
);

    logic                 r_a_valid;
    logic signed [31:0]   r_cos;
    logic signed [31:0]   r_sin;
    logic signed [47:0]   r_a_pz;

    logic                 r_b_valid;
    logic signed [63:0]   r_pxp;
    logic signed [63:0]   r_pyp;
    logic signed [63:0]   r_txp;
    logic signed [63:0]   r_typ;
    logic signed [47:0]   r_b_pz;

    logic                 r_c_valid;
    logic signed [33:0]   r_px;
    logic signed [33:0]   r_py;
    logic signed [33:0]   r_tx;
    logic signed [33:0]   r_ty;
    logic signed [47:0]   r_c_pz;

    logic signed [63:0]   r_tz_prod;
    logic signed [31:0]   r_tz;

    logic                 r_out_valid;
    logic                 r_skid_valid;
    pcpt_pkg::t_result    r_out;
    pcpt_pkg::t_result    r_skid;
    pcpt_pkg::t_result    n_res;

    logic [1:0]           n_kind;
    logic [31:0]          n_ry;
    logic signed [63:0]   n_tz_sum;
    logic                 n_helix;

    function automatic logic signed [63:0] ext34(input logic signed [33:0] v);
        return {{30{v[33]}}, v};
    endfunction

    always_comb begin
        if (i_cfg.kind == pcpt_pkg::CURVE_ELLIPSE || i_cfg.kind == pcpt_pkg::CURVE_HELIX) begin
            n_kind = i_cfg.kind;
        end else begin
            n_kind = pcpt_pkg::CURVE_CIRCLE;
        end
        n_helix  = (n_kind == pcpt_pkg::CURVE_HELIX);
        n_ry     = (n_kind == pcpt_pkg::CURVE_ELLIPSE) ? i_cfg.radius_y : i_cfg.radius_x;
        n_tz_sum = r_tz_prod + 64'sd2147483648 - {63'd0, r_tz_prod[63]};
    end

    // follows the pitch register, settles well before any word gets here
    always_ff @(posedge i_clk) begin
        r_tz_prod <= i_cfg.pitch * $signed({1'b0, pcpt_pkg::INV_TWO_PI_Q32});
        r_tz      <= n_tz_sum[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_word.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos  <= i_word.neg ? -i_word.x : i_word.x;
            r_sin  <= i_word.neg ? -i_word.y : i_word.y;
            r_a_pz <= i_word.pz;
            r_pxp  <= $signed({1'b0, i_cfg.radius_x}) * r_cos;
            r_pyp  <= $signed({1'b0, n_ry}) * r_sin;
            r_txp  <= $signed({1'b0, i_cfg.radius_x}) * r_sin;
            r_typ  <= $signed({1'b0, n_ry}) * r_cos;
            r_b_pz <= r_a_pz;
            r_px   <= pcpt_pkg::round30(r_pxp);
            r_py   <= pcpt_pkg::round30(r_pyp);
            r_tx   <= pcpt_pkg::round30(r_txp);
            r_ty   <= pcpt_pkg::round30(r_typ);
            r_c_pz <= r_b_pz;
        end
    end

    always_comb begin
        n_res.point_x   = pcpt_pkg::sat48(ext34(r_px));
        n_res.point_y   = pcpt_pkg::sat48(ext34(r_py));
        n_res.point_z   = n_helix ? r_c_pz : '0;
        n_res.tangent_x = pcpt_pkg::sat48(-ext34(r_tx));
        n_res.tangent_y = pcpt_pkg::sat48(ext34(r_ty));
        n_res.tangent_z = n_helix ? {{16{r_tz[31]}}, r_tz} : '0;
        n_res.kind      = n_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (!i_stall) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_en && r_c_valid) begin
            if (r_out_valid && i_stall) begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end else begin
                r_out       <= n_res;
                r_out_valid <= 1'b1;
            end
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_full   = r_skid_valid;
    assign o_result = r_out;

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without an output word");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid filled while output was free");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> !r_skid_valid)
        else $error("skid did not drain");

    a_flat_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.kind != pcpt_pkg::CURVE_HELIX)
        |-> (o_result.point_z == '0 && o_result.tangent_z == '0))
        else $error("nonzero z on a flat curve");

endmodule

FILE: design/parametric_curve_point_tangent_top.sv
// ----------------------------------------------------------------------------
// parametric_curve_point_tangent_top: circle, ellipse and helix evaluator
// Each word passes angle reduction, the CORDIC cell row and the output stage.
// Throughput: one word per cycle, set by the CORDIC cell row; stalls only
// when the output skid register is full.
// Reset (synchronous, active low) empties the pipeline and loads curve kind
// circle, both radii 1.0 and pitch 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module parametric_curve_point_tangent_top #(
    parameter int unsigned CORDIC_STAGES = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_angle,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [47:0]  o_point_x,
    output logic signed [47:0]  o_point_y,
    output logic signed [47:0]  o_point_z,
    output logic signed [47:0]  o_tangent_x,
    output logic signed [47:0]  o_tangent_y,
    output logic signed [47:0]  o_tangent_z,
    output logic [1:0]          o_curve_type
);

    pcpt_pkg::t_cfg         r_cfg;
    pcpt_pkg::t_cordic_word w_chain [CORDIC_STAGES+1];
    pcpt_pkg::t_result      w_result;
    logic                   w_full;
    logic                   w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind     <= pcpt_pkg::CURVE_CIRCLE;
            r_cfg.radius_x <= 32'd65536;
            r_cfg.radius_y <= 32'd65536;
            r_cfg.pitch    <= '0;
        end else if (i_cfg_we) begin
            case (pcpt_pkg::t_cfg_idx'(i_cfg_index))
                pcpt_pkg::CFG_CURVE_KIND: r_cfg.kind     <= i_cfg_data[1:0];
                pcpt_pkg::CFG_RADIUS_X:   r_cfg.radius_x <= i_cfg_data;
                pcpt_pkg::CFG_RADIUS_Y:   r_cfg.radius_y <= i_cfg_data;
                pcpt_pkg::CFG_PITCH:      r_cfg.pitch    <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign w_en    = !w_full;
    assign o_stall = w_full;

    pcpt_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_angle (i_angle),
        .i_cfg   (r_cfg),
        .o_word  (w_chain[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        pcpt_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_word  (w_chain[g]),
            .o_word  (w_chain[g+1])
        );
    end

    pcpt_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_word   (w_chain[CORDIC_STAGES]),
        .i_cfg    (r_cfg),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_full   (w_full),
        .o_result (w_result)
    );

    assign o_point_x    = w_result.point_x;
    assign o_point_y    = w_result.point_y;
    assign o_point_z    = w_result.point_z;
    assign o_tangent_x  = w_result.tangent_x;
    assign o_tangent_y  = w_result.tangent_y;
    assign o_tangent_z  = w_result.tangent_z;
    assign o_curve_type = w_result.kind;

endmodule

FILE: sim/tb_parametric_curve_point_tangent_top.sv
// ----------------------------------------------------------------------------
// tb_parametric_curve_point_tangent_top: curve point and tangent testbench
// Drives angle words through the evaluator under random sender gaps and receiver
// stalls. Each accepted angle is predicted by a bit-exact CORDIC model of the
// circle, ellipse and helix evaluation, or taken from its row if that row is typed.
// Each output word is compared field by field with the oldest prediction. A short
// directed table runs first, then random phases, each with its own register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_parametric_curve_point_tangent_top;

    localparam int unsigned CORDIC_STEPS = 24;
    localparam int LATENCY     = 12 + CORDIC_STEPS;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 128;

    localparam longint TURN         = 64'sd105414357;
    localparam longint HALF_TURN    = 64'sd52707179;
    localparam longint QUARTER_TURN = 64'sd26353589;
    localparam longint CORDIC_GAIN  = 64'sd652032874;
    localparam longint INV_TURN_Q32 = 64'sd683565276;
    localparam longint SAT_HI       = 64'sd140737488355327;
    localparam longint SAT_LO       = -64'sd140737488355328;
    localparam longint ATAN_Q30 [10] = '{
        64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
        64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
        64'sd4194282,   64'sd2097149
    };

    localparam logic [1:0]         KIND_UNUSED = 2'd3;
    localparam logic [31:0]        R_ONE       = 32'h0001_0000;
    localparam logic [31:0]        R_MAX       = 32'hFFFF_FFFF;
    localparam logic signed [31:0] S32_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] ANG_PI      = 32'sd52707179;
    localparam logic signed [31:0] ANG_HALF_PI = 32'sd26353589;
    localparam logic signed [31:0] ANG_TWO_PI  = 32'sd105414357;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        rx;
        logic [31:0]        ry;
        logic signed [31:0] pitch;
        logic signed [31:0] angle;
        logic               typed;
        pcpt_pkg::t_result  want;
    } t_row;

    localparam int PLAN_ROWS = 23;
    localparam t_row ANGLE_PLAN [PLAN_ROWS] = '{
        '{pcpt_pkg::CURVE_CIRCLE, R_ONE, R_ONE, 32'sd0, 32'sd0, 1'b1,
          '{48'sd65536, 48'sd0, 48'sd0, 48'sd0, 48'sd65536, 48'sd0,
            pcpt_pkg::CURVE_CIRCLE}},
        '{pcpt_pkg::CURVE_CIRCLE, R_ONE, R_ONE, 32'sd0, S32_MAX, 1'b0, '0},
        '{pcpt_pkg::CURVE_CIRCLE, R_ONE, R_ONE, 32'sd0, S32_MIN, 1'b0, '0},
        '{pcpt_pkg::CURVE_CIRCLE, R_ONE, R_ONE, 32'sd0, ANG_PI, 1'b0, '0},
        '{pcpt_pkg::CURVE_CIRCLE, R_ONE, R_ONE, 32'sd0, -ANG_PI, 1'b0, '0},
        '{pcpt_pkg::CURVE_CIRCLE, R_ONE, R_ONE, 32'sd0, ANG_HALF_PI, 1'b0, '0},
        '{pcpt_pkg::CURVE_CIRCLE, R_ONE, R_ONE, 32'sd0, ANG_HALF_PI + 32'sd1, 1'b0, '0},
        '{pcpt_pkg::CURVE_CIRCLE, R_ONE, R_ONE, 32'sd0, -ANG_HALF_PI, 1'b0, '0},
        '{pcpt_pkg::CURVE_CIRCLE, R_ONE, R_ONE, 32'sd0, -ANG_HALF_PI - 32'sd1, 1'b0, '0},
        '{pcpt_pkg::CURVE_CIRCLE, R_ONE, R_ONE, 32'sd0, ANG_TWO_PI, 1'b0, '0},
        '{pcpt_pkg::CURVE_CIRCLE, R_ONE, R_ONE, 32'sd0, -32'sd1, 1'b0, '0},
        '{pcpt_pkg::CURVE_ELLIPSE, R_MAX, 32'd0, 32'sd0, S32_MAX, 1'b0, '0},
        '{pcpt_pkg::CURVE_ELLIPSE, 32'd0, R_MAX, 32'sd0, ANG_HALF_PI, 1'b0, '0},
        '{pcpt_pkg::CURVE_ELLIPSE, R_MAX, R_MAX, 32'sd0, -ANG_PI, 1'b0, '0},
        '{pcpt_pkg::CURVE_CIRCLE, 32'h0003_0000, R_MAX, 32'sd0, 32'sd12345678,
          1'b0, '0},
        '{pcpt_pkg::CURVE_CIRCLE, 32'd0, R_MAX, 32'sd0, S32_MIN, 1'b1,
          '{48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, pcpt_pkg::CURVE_CIRCLE}},
        '{pcpt_pkg::CURVE_HELIX, R_ONE, R_ONE, S32_MAX, S32_MAX, 1'b0, '0},
        '{pcpt_pkg::CURVE_HELIX, R_MAX, 32'd0, S32_MIN, S32_MIN, 1'b0, '0},
        '{pcpt_pkg::CURVE_HELIX, R_MAX, 32'd0, S32_MIN, S32_MAX, 1'b0, '0},
        '{pcpt_pkg::CURVE_HELIX, 32'd0, R_MAX, 32'sd0, 32'sd0, 1'b1,
          '{48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, pcpt_pkg::CURVE_HELIX}},
        '{pcpt_pkg::CURVE_HELIX, 32'h0001_8000, 32'd0, -32'sd65536, -ANG_PI, 1'b0, '0},
        '{KIND_UNUSED, 32'd0, 32'd0, S32_MAX, S32_MAX, 1'b1,
          '{48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, 48'sd0, pcpt_pkg::CURVE_CIRCLE}},
        '{KIND_UNUSED, 32'h0002_0000, 32'h0000_5000, 32'sh4000_0000, 32'sd33554432,
          1'b0, '0}
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_index = pcpt_pkg::CFG_CURVE_KIND;
    logic [31:0]         i_cfg_data = 32'd0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic signed [31:0]  i_angle = 32'sd0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic signed [47:0]  o_point_x;
    logic signed [47:0]  o_point_y;
    logic signed [47:0]  o_point_z;
    logic signed [47:0]  o_tangent_x;
    logic signed [47:0]  o_tangent_y;
    logic signed [47:0]  o_tangent_z;
    logic [1:0]          o_curve_type;

    logic [1:0]          cfg_kind = pcpt_pkg::CURVE_CIRCLE;
    logic [31:0]         cfg_rx = R_ONE;
    logic [31:0]         cfg_ry = R_ONE;
    logic signed [31:0]  cfg_pitch = 32'sd0;

    pcpt_pkg::t_result   pending_results [$];
    logic                next_typed = 1'b0;
    pcpt_pkg::t_result   next_want = '0;
    int                  mismatch_count = 0;
    bit                  calm = 1'b0;
    int                  gap_pct = 20;
    int                  stall_pct = 20;

    parametric_curve_point_tangent_top #(
        .CORDIC_STAGES(CORDIC_STEPS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_angle(i_angle),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_point_x(o_point_x),
        .o_point_y(o_point_y),
        .o_point_z(o_point_z),
        .o_tangent_x(o_tangent_x),
        .o_tangent_y(o_tangent_y),
        .o_tangent_z(o_tangent_z),
        .o_curve_type(o_curve_type)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint half_away(input longint v, input int unsigned s);
        longint half;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0) begin
            return (v + half) >>> s;
        end
        return -((-v + half) >>> s);
    endfunction

    function automatic logic signed [47:0] clip48(input longint v);
        longint c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return c[47:0];
    endfunction

    function automatic pcpt_pkg::t_result eval_curve(input logic signed [31:0] angle);
        longint ang, r, x, y, z, dx, dy, da, sn, cs, rx, ry, pch, pz, tz, prod;
        logic [127:0] mag, q;
        bit flip;
        int i;
        pcpt_pkg::t_curve kind;
        pcpt_pkg::t_result res;
        ang = angle;
        rx = cfg_rx;
        pch = cfg_pitch;
        kind = (cfg_kind == KIND_UNUSED) ? pcpt_pkg::CURVE_CIRCLE
                                         : pcpt_pkg::t_curve'(cfg_kind);
        ry = (kind == pcpt_pkg::CURVE_ELLIPSE) ? cfg_ry : cfg_rx;
        // reduce to one turn, then fold into the right half plane
        r = ang % TURN;
        if (r < 0) begin
            r += TURN;
        end
        if (r >= HALF_TURN) begin
            r -= TURN;
        end
        flip = 1'b0;
        if (r > QUARTER_TURN) begin
            r -= HALF_TURN;
            flip = 1'b1;
        end else if (r < -QUARTER_TURN) begin
            r += HALF_TURN;
            flip = 1'b1;
        end
        x = CORDIC_GAIN;
        y = 0;
        z = r * 64;
        for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (i < 10) begin
                da = ATAN_Q30[i];
            end else if (i < 30) begin
                da = (64'sd1 <<< (30 - i)) - 1;
            end else begin
                da = 0;
            end
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= da;
            end else begin
                x += dx;
                y -= dy;
                z += da;
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
        pz = 0;
        tz = 0;
        if (kind == pcpt_pkg::CURVE_HELIX) begin
            tz = half_away(pch * INV_TURN_Q32, 32);
            prod = pch * ang;
            mag = (prod < 0) ? -prod : prod;
            q = (mag * 128'd683565276 + (128'd1 << 55)) >> 56;
            pz = q[63:0];
            if (prod < 0) begin
                pz = -pz;
            end
        end
        res.point_x = clip48(half_away(rx * cs, 30));
        res.point_y = clip48(half_away(ry * sn, 30));
        res.point_z = clip48(pz);
        res.tangent_x = clip48(-half_away(rx * sn, 30));
        res.tangent_y = clip48(half_away(ry * cs, 30));
        res.tangent_z = clip48(tz);
        res.kind = kind;
        return res;
    endfunction

    task automatic check_field(input string name, input logic signed [47:0] want,
                               input logic signed [47:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        pcpt_pkg::t_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                pending_results.push_back(next_typed ? next_want : eval_curve(i_angle));
            end
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("output word with no prediction waiting");
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("point_x", want.point_x, o_point_x);
                    check_field("point_y", want.point_y, o_point_y);
                    check_field("point_z", want.point_z, o_point_z);
                    check_field("tangent_x", want.tangent_x, o_tangent_x);
                    check_field("tangent_y", want.tangent_y, o_tangent_y);
                    check_field("tangent_z", want.tangent_z, o_tangent_z);
                    check_field("curve_type", want.kind, o_curve_type);
                end
            end
        end
    end

    always begin : receiver
        int n;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < stall_pct) begin
            n = $urandom_range(1, 5);
            i_stall <= 1'b1;
            repeat (n) @(negedge i_clk);
            i_stall <= 1'b0;
        end
    end

    task automatic write_reg(input pcpt_pkg::t_cfg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            pcpt_pkg::CFG_CURVE_KIND: cfg_kind = value[1:0];
            pcpt_pkg::CFG_RADIUS_X:   cfg_rx = value;
            pcpt_pkg::CFG_RADIUS_Y:   cfg_ry = value;
            pcpt_pkg::CFG_PITCH:      cfg_pitch = value;
            default:                  ;
        endcase
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_word(input logic signed [31:0] angle, input logic typed,
                             input pcpt_pkg::t_result want);
        int n;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            n = $urandom_range(1, 5);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_angle <= angle;
        next_typed = typed;
        next_want = want;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic [31:0] pick_radius();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return R_MAX;
            2, 3:    return $urandom;
            default: return $urandom_range(0, 32'h00FF_FFFF);
        endcase
    endfunction

    initial begin : run
        int k, ph, n, step;
        t_row row;
        logic signed [31:0] ang;
        logic signed [31:0] pch;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < PLAN_ROWS; k++) begin
            row = ANGLE_PLAN[k];
            if (row.kind != cfg_kind || row.rx != cfg_rx || row.ry != cfg_ry ||
                row.pitch != cfg_pitch) begin
                drain_results();
                if (row.kind != cfg_kind) begin
                    write_reg(pcpt_pkg::CFG_CURVE_KIND, {30'd0, row.kind});
                end
                if (row.rx != cfg_rx) write_reg(pcpt_pkg::CFG_RADIUS_X, row.rx);
                if (row.ry != cfg_ry) write_reg(pcpt_pkg::CFG_RADIUS_Y, row.ry);
                if (row.pitch != cfg_pitch) write_reg(pcpt_pkg::CFG_PITCH, row.pitch);
            end
            send_word(row.angle, row.typed, row.want);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            drain_results();
            calm = (ph == PHASES - 1);
            gap_pct = calm ? 0 : $urandom_range(0, 40);
            stall_pct = calm ? 0 : $urandom_range(0, 40);
            case ($urandom_range(0, 4))
                0:       pch = S32_MAX;
                1:       pch = S32_MIN;
                2:       pch = $urandom;
                3:       pch = int'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
                default: pch = 32'sd0;
            endcase
            write_reg(pcpt_pkg::CFG_CURVE_KIND, $urandom_range(0, 3));
            write_reg(pcpt_pkg::CFG_RADIUS_X, pick_radius());
            write_reg(pcpt_pkg::CFG_RADIUS_Y, pick_radius());
            write_reg(pcpt_pkg::CFG_PITCH, pch);
            for (n = 0; n < PHASE_WORDS; n++) begin
                // in phase 3 only, hold off until the pipeline runs dry once mid-phase
                if (ph == 3 && n == PHASE_WORDS / 2) drain_results();
                case ($urandom_range(0, 9))
                    6: begin
                        step = int'($urandom_range(0, 160)) - 80;
                        ang = ANG_HALF_PI * step + int'($urandom_range(0, 8)) - 4;
                    end
                    7: ang = int'($urandom_range(0, 210828714)) - 105414357;
                    8: ang = $urandom_range(0, 1) ? S32_MAX - int'($urandom_range(0, 15))
                                                  : S32_MIN + int'($urandom_range(0, 15));
                    default: ang = $urandom;
                endcase
                send_word(ang, 1'b0, '0);
            end
        end

        drain_results();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #(3_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
